@@ design/iirt_pkg.sv @@
// Shared types, constants, saturation helpers and the microcode program
// of the multi-channel transposed direct form II IIR filter.
// No dependencies.
package iirt_pkg;

   // Default sizes handed to the top level
   localparam int FILTER_ORDER_DEF = 3;
   localparam int MAX_CHANNELS_DEF = 8;

   // Coefficient registers are Q4.28, four numerator and four denominator slots
   localparam int NUM_COEF_REGS = 4;

   // Field widths
   localparam int CH_W     = 3;
   localparam int SAMPLE_W = 24;
   localparam int COEF_W   = 32;
   localparam int WORD_W   = 48;
   localparam int CSR_IDX_W = 3;
   localparam int CHUSE_W  = 4;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef coef_type coef_set_type [NUM_COEF_REGS];

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COEF_0      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COEF_1      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COEF_2      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COEF_3      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEN_COEF_1      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEN_COEF_2      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DEN_COEF_3      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS_IN_USE = 3'd7;

   localparam logic [CHUSE_W-1:0] CHANNELS_IN_USE_RST = 4'd1;

   // Saturation bounds
   localparam logic signed [54:0] W48_MAX = 55'sd140737488355327;
   localparam logic signed [54:0] W48_MIN = -W48_MAX - 55'sd1;
   localparam logic signed [24:0] S24_MAX = 25'sd8388607;
   localparam logic signed [24:0] S24_MIN = -25'sd8388608;

   // Program addresses of the sequencer
   typedef logic [2:0] step_type;
   localparam step_type STEP_IDLE  = 3'd0;
   localparam step_type STEP_READ0 = 3'd1;
   localparam step_type STEP_YCALC = 3'd2;
   localparam step_type STEP_TMUL  = 3'd3;
   localparam step_type STEP_TAY   = 3'd4;
   localparam step_type STEP_TSUM  = 3'd5;
   localparam step_type STEP_OUT   = 3'd6;
   localparam step_type STEP_ERR   = 3'd7;

   // How the step counter moves on
   typedef enum logic [1:0] {
      JMP_NEXT,  // fall through
      JMP_REQ,   // hold until a transaction arrives; bad channel jumps to target
      JMP_TAP,   // jump to target unless the last tap was just done
      JMP_RSP    // hold until the result register is free, then jump to target
   } jmp_type;

   // One microcode word
   typedef struct packed {
      logic     accept;
      logic     rd_w;
      logic     mul;
      logic     y_load;
      logic     ay_load;
      logic     w_write;
      logic     k_clr;
      logic     k_inc;
      logic     rsp_load;
      logic     rsp_err;
      jmp_type  jmp;
      step_type target;
   } ctrl_word_type;

   // Strobes from sequencer to datapath
   typedef struct packed {
      logic rd_w;
      logic mul;
      logic y_load;
      logic ay_load;
      logic w_write;
   } dp_ctl_type;

   // Strobes from sequencer to the result register
   typedef struct packed {
      logic load;
      logic err;
   } rsp_ctl_type;

   // Program ROM
   function automatic ctrl_word_type ucode(input step_type s);
      ctrl_word_type cw;
      cw        = '0;
      cw.jmp    = JMP_NEXT;
      cw.target = STEP_IDLE;
      unique case (s)
         STEP_IDLE: begin
            cw.accept = 1'b1;
            cw.k_clr  = 1'b1;
            cw.jmp    = JMP_REQ;
            cw.target = STEP_ERR;
         end
         STEP_READ0: begin
            cw.rd_w = 1'b1;
            cw.mul  = 1'b1;
         end
         STEP_YCALC: begin
            cw.y_load = 1'b1;
            cw.k_inc  = 1'b1;
         end
         STEP_TMUL: begin
            cw.rd_w = 1'b1;
            cw.mul  = 1'b1;
         end
         STEP_TAY: begin
            cw.ay_load = 1'b1;
         end
         STEP_TSUM: begin
            cw.w_write = 1'b1;
            cw.k_inc   = 1'b1;
            cw.jmp     = JMP_TAP;
            cw.target  = STEP_TMUL;
         end
         STEP_OUT: begin
            cw.rsp_load = 1'b1;
            cw.jmp      = JMP_RSP;
            cw.target   = STEP_IDLE;
         end
         STEP_ERR: begin
            cw.rsp_load = 1'b1;
            cw.rsp_err  = 1'b1;
            cw.jmp      = JMP_RSP;
            cw.target   = STEP_IDLE;
         end
      endcase
      return cw;
   endfunction

   // Clamp a wide sum to signed 48 bits
   function automatic logic signed [WORD_W-1:0] sat48(input logic signed [54:0] v);
      logic signed [54:0] c;
      c = v;
      if (v > W48_MAX) begin
         c = W48_MAX;
      end else if (v < W48_MIN) begin
         c = W48_MIN;
      end
      return c[WORD_W-1:0];
   endfunction

   // Clamp to signed 24 bits
   function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [24:0] v);
      logic signed [24:0] c;
      c = v;
      if (v > S24_MAX) begin
         c = S24_MAX;
      end else if (v < S24_MIN) begin
         c = S24_MIN;
      end
      return c[SAMPLE_W-1:0];
   endfunction

endpackage

@@ design/iirt_mem.sv @@
// Delay word store: one write port, one registered read port.
// Depends on iirt_pkg.
module iirt_mem #(
   parameter int DEPTH  = 24,
   parameter int ADDR_W = 5
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic signed [iirt_pkg::WORD_W-1:0] wr_data,
   input  logic                          rd_en,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic signed [iirt_pkg::WORD_W-1:0] rd_data
);
   import iirt_pkg::*;

   logic signed [WORD_W-1:0] mem [DEPTH];
   logic signed [WORD_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/iirt_dp.sv @@
// Datapath: item registers, coefficient select, three multipliers,
// feedback accumulate with saturation and output rounding.
// Depends on iirt_pkg.
module iirt_dp #(
   parameter int FILTER_ORDER = 3,
   parameter int ADDR_W       = 5,
   parameter int K_W          = 2
) (
   input  logic                                 clock,
   input  logic                                 req_fire,
   input  logic [iirt_pkg::CH_W-1:0]            req_channel,
   input  logic signed [iirt_pkg::SAMPLE_W-1:0] req_sample,
   input  iirt_pkg::coef_set_type               num_coef,
   input  iirt_pkg::coef_set_type               den_coef,
   input  iirt_pkg::dp_ctl_type                 ctl,
   input  logic [K_W-1:0]                       k,
   input  logic signed [iirt_pkg::WORD_W-1:0]   mem_rd_data,
   output logic                                 mem_rd_en,
   output logic [ADDR_W-1:0]                    mem_rd_addr,
   output logic                                 mem_wr_en,
   output logic [ADDR_W-1:0]                    mem_wr_addr,
   output logic signed [iirt_pkg::WORD_W-1:0]   mem_wr_data,
   output logic [iirt_pkg::CH_W-1:0]            ch,
   output logic signed [iirt_pkg::SAMPLE_W-1:0] filtered
);
   import iirt_pkg::*;

   logic [CH_W-1:0]            ch_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [55:0]         pbx_ff, pbx_in;
   logic signed [55:0]         p1_ff, p1_in;
   logic signed [56:0]         p0_ff, p0_in;
   logic signed [WORD_W-1:0]   y_ff, y_in;
   logic signed [52:0]         ay_ff, ay_in;

   logic                       tap_hi;
   logic                       tap_has_w;
   coef_type                   b_sel, a_sel;
   logic signed [23:0]         y_hi;
   logic signed [24:0]         y_lo;
   logic signed [51:0]         bx_term;
   logic signed [52:0]         y_sum;
   logic signed [80:0]         ay_full;
   logic signed [WORD_W-1:0]   w_term;
   logic signed [54:0]         t_sum;
   logic signed [48:0]         y_round;
   logic [ADDR_W-1:0]          base;

   // Item registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         ch_ff <= req_channel;
         x_ff  <= req_sample;
      end
   end

   // Coefficients beyond b3 / a3 read as zero
   always_comb begin
      tap_hi    = (k > K_W'(NUM_COEF_REGS - 1));
      tap_has_w = (k < K_W'(FILTER_ORDER));
      b_sel     = tap_hi ? '0 : num_coef[k[1:0]];
      a_sel     = tap_hi ? '0 : den_coef[k[1:0]];
   end

   // Multipliers; a*y is split into high signed and low unsigned halves of y
   always_comb begin
      y_hi   = y_ff[WORD_W-1:24];
      y_lo   = $signed({1'b0, y_ff[23:0]});
      pbx_in = 56'(b_sel) * 56'(x_ff);
      p1_in  = 56'(a_sel) * 56'(y_hi);
      p0_in  = 57'(a_sel) * 57'(y_lo);
   end

   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         pbx_ff <= pbx_in;
         p1_ff  <= p1_in;
         p0_ff  <= p0_in;
      end
   end

   // b*x in Q24.24 (floor), y = b0*x + w0
   always_comb begin
      bx_term = pbx_ff[55:4];
      y_sum   = 53'(bx_term) + 53'(mem_rd_data);
      y_in    = sat48(55'(y_sum));
   end

   always_ff @(posedge clock) begin
      if (ctl.y_load) begin
         y_ff <= y_in;
      end
   end

   // a*y recombined and floored to Q24.24
   always_comb begin
      ay_full = (81'(p1_ff) <<< 24) + 81'(p0_ff);
      ay_in   = ay_full[80:28];
   end

   always_ff @(posedge clock) begin
      if (ctl.ay_load) begin
         ay_ff <= ay_in;
      end
   end

   // New delay word; the last one takes no w term
   always_comb begin
      w_term = tap_has_w ? mem_rd_data : '0;
      t_sum  = 55'(bx_term) + 55'(w_term) - 55'(ay_ff);
   end

   // Delay word addressing
   always_comb begin
      base        = ADDR_W'(ch_ff) * ADDR_W'(FILTER_ORDER);
      mem_rd_en   = ctl.rd_w & tap_has_w;
      mem_rd_addr = base + ADDR_W'(k);
      mem_wr_en   = ctl.w_write;
      mem_wr_addr = base + ADDR_W'(k) - ADDR_W'(1);
      mem_wr_data = sat48(t_sum);
   end

   // Round half up and clamp to 24 bits
   always_comb begin
      y_round  = 49'(y_ff) + 49'sd8388608;
      filtered = sat24(y_round[48:24]);
      ch       = ch_ff;
   end

endmodule

@@ design/iirt_seq.sv @@
// Microcoded sequencer: step counter, program ROM lookup, tap counter
// and the delay word clearing pass after reset. Depends on iirt_pkg.
module iirt_seq #(
   parameter int FILTER_ORDER = 3,
   parameter int DEPTH        = 24,
   parameter int ADDR_W       = 5,
   parameter int K_W          = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  item_err,
   input  logic                  rsp_free,
   output logic                  req_ready,
   output iirt_pkg::dp_ctl_type  dp_ctl,
   output iirt_pkg::rsp_ctl_type rsp_ctl,
   output logic [K_W-1:0]        k,
   output logic                  clearing,
   output logic [ADDR_W-1:0]     clr_addr
);
   import iirt_pkg::*;

   step_type          step_ff, step_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   ctrl_word_type     cw;
   logic              req_fire;
   logic              last_tap;

   // Control word of the current step
   assign cw        = ucode(step_ff);
   assign req_ready = cw.accept & ~clearing_ff;
   assign req_fire  = req_valid & req_ready;
   assign last_tap  = (k_ff == K_W'(FILTER_ORDER));

   // Next step
   always_comb begin
      step_in = step_ff;
      unique case (cw.jmp)
         JMP_NEXT: step_in = step_ff + step_type'(1);
         JMP_REQ: begin
            if (req_fire) begin
               step_in = item_err ? cw.target : step_ff + step_type'(1);
            end
         end
         JMP_TAP: step_in = last_tap ? step_ff + step_type'(1) : cw.target;
         JMP_RSP: begin
            if (rsp_free) begin
               step_in = cw.target;
            end
         end
         default: step_in = STEP_IDLE;
      endcase
   end

   // Tap counter
   always_comb begin
      k_in = k_ff;
      if (cw.k_clr) begin
         k_in = '0;
      end else if (cw.k_inc) begin
         k_in = k_ff + K_W'(1);
      end
   end

   // Clearing pass over the delay words
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= STEP_IDLE;
         k_ff        <= '0;
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         step_ff     <= step_in;
         k_ff        <= k_in;
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Strobes
   always_comb begin
      dp_ctl.rd_w    = cw.rd_w;
      dp_ctl.mul     = cw.mul;
      dp_ctl.y_load  = cw.y_load;
      dp_ctl.ay_load = cw.ay_load;
      dp_ctl.w_write = cw.w_write;
      rsp_ctl.load   = cw.rsp_load & rsp_free;
      rsp_ctl.err    = cw.rsp_err;
   end

   assign k        = k_ff;
   assign clearing = clearing_ff;
   assign clr_addr = clr_addr_ff;

endmodule

@@ design/multichannel_iir_transposed_df2_top.sv @@
// Top level of the multi-channel IIR filter, transposed direct form II.
// Depends on iirt_pkg, iirt_mem, iirt_dp and iirt_seq.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_ready   req_channel, req_sample
//   rsp_      out        rsp_valid/rsp_ready   rsp_channel_out, rsp_filtered,
//                                              rsp_channel_error
//   csr_      in         csr_valid/csr_ready   csr_index, csr_data
//
// A served channel goes from acceptance through READ0 and YCALC, then TMUL, TAY
// and TSUM for each tap, then OUT back to IDLE; a bad channel goes through ERR.
// The taps run one after the other through one set of three multipliers and the
// read and write ports of the delay memory. After reset a clearing pass zeroes
// the delay words; no transaction is accepted meanwhile, configuration always is.
// The result register frees the sequencer: the next transaction is taken while
// a result waits; the sequencer stalls only when a second result is ready.
module multichannel_iir_transposed_df2_top #(
   parameter int FILTER_ORDER = iirt_pkg::FILTER_ORDER_DEF,
   parameter int MAX_CHANNELS = iirt_pkg::MAX_CHANNELS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [iirt_pkg::CH_W-1:0]            req_channel,
   input  logic signed [iirt_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [iirt_pkg::CH_W-1:0]            rsp_channel_out,
   output logic signed [iirt_pkg::SAMPLE_W-1:0] rsp_filtered,
   output logic                                 rsp_channel_error,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [iirt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [iirt_pkg::COEF_W-1:0]          csr_data
);
   import iirt_pkg::*;

   localparam int DEPTH  = MAX_CHANNELS * FILTER_ORDER;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int K_BITS = $clog2(FILTER_ORDER + 1);
   localparam int K_W    = (K_BITS > 2) ? K_BITS : 2;

   coef_set_type         num_coef_ff;
   coef_set_type         den_coef_ff;
   logic [CHUSE_W-1:0]   ch_use_ff;

   logic                 rsp_valid_ff;
   logic [CH_W-1:0]      rsp_channel_ff;
   logic signed [SAMPLE_W-1:0] rsp_filtered_ff;
   logic                 rsp_error_ff;

   logic                 csr_fire;
   logic                 req_fire;
   logic                 item_err;
   logic                 rsp_free;
   dp_ctl_type           dp_ctl;
   rsp_ctl_type          rsp_ctl;
   logic [K_W-1:0]       k;
   logic                 clearing;
   logic [ADDR_W-1:0]    clr_addr;

   logic                 dp_rd_en, dp_wr_en;
   logic [ADDR_W-1:0]    dp_rd_addr, dp_wr_addr;
   logic signed [WORD_W-1:0] dp_wr_data, mem_rd_data;
   logic                 mem_wr_en;
   logic [ADDR_W-1:0]    mem_wr_addr;
   logic signed [WORD_W-1:0] mem_wr_data;
   logic [CH_W-1:0]      dp_ch;
   logic signed [SAMPLE_W-1:0] dp_filtered;

   // Configuration registers
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_coef_ff <= '{default: '0};
         den_coef_ff <= '{default: '0};
         ch_use_ff   <= CHANNELS_IN_USE_RST;
      end else if (csr_fire) begin
         unique case (csr_index)
            CSR_NUM_COEF_0:      num_coef_ff[0] <= $signed(csr_data);
            CSR_NUM_COEF_1:      num_coef_ff[1] <= $signed(csr_data);
            CSR_NUM_COEF_2:      num_coef_ff[2] <= $signed(csr_data);
            CSR_NUM_COEF_3:      num_coef_ff[3] <= $signed(csr_data);
            CSR_DEN_COEF_1:      den_coef_ff[1] <= $signed(csr_data);
            CSR_DEN_COEF_2:      den_coef_ff[2] <= $signed(csr_data);
            CSR_DEN_COEF_3:      den_coef_ff[3] <= $signed(csr_data);
            CSR_CHANNELS_IN_USE: ch_use_ff      <= csr_data[CHUSE_W-1:0];
         endcase
      end
   end

   // Channel check on the incoming transaction
   assign req_fire = req_valid & req_ready;
   assign item_err = ({1'b0, req_channel} >= ch_use_ff)
                     || (32'(req_channel) >= 32'(MAX_CHANNELS));
   assign rsp_free = ~rsp_valid_ff | rsp_ready;

   iirt_seq #(
      .FILTER_ORDER (FILTER_ORDER),
      .DEPTH        (DEPTH),
      .ADDR_W       (ADDR_W),
      .K_W          (K_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .item_err  (item_err),
      .rsp_free  (rsp_free),
      .req_ready (req_ready),
      .dp_ctl    (dp_ctl),
      .rsp_ctl   (rsp_ctl),
      .k         (k),
      .clearing  (clearing),
      .clr_addr  (clr_addr)
   );

   iirt_dp #(
      .FILTER_ORDER (FILTER_ORDER),
      .ADDR_W       (ADDR_W),
      .K_W          (K_W)
   ) u_dp (
      .clock       (clock),
      .req_fire    (req_fire),
      .req_channel (req_channel),
      .req_sample  (req_sample),
      .num_coef    (num_coef_ff),
      .den_coef    (den_coef_ff),
      .ctl         (dp_ctl),
      .k           (k),
      .mem_rd_data (mem_rd_data),
      .mem_rd_en   (dp_rd_en),
      .mem_rd_addr (dp_rd_addr),
      .mem_wr_en   (dp_wr_en),
      .mem_wr_addr (dp_wr_addr),
      .mem_wr_data (dp_wr_data),
      .ch          (dp_ch),
      .filtered    (dp_filtered)
   );

   // Clearing pass owns the write port after reset
   always_comb begin
      mem_wr_en   = clearing | dp_wr_en;
      mem_wr_addr = clearing ? clr_addr : dp_wr_addr;
      mem_wr_data = clearing ? '0 : dp_wr_data;
   end

   iirt_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (dp_rd_en),
      .rd_addr (dp_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ctl.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ctl.load) begin
         rsp_channel_ff  <= dp_ch;
         rsp_filtered_ff <= rsp_ctl.err ? '0 : dp_filtered;
         rsp_error_ff    <= rsp_ctl.err;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_channel_out   = rsp_channel_ff;
   assign rsp_filtered      = rsp_filtered_ff;
   assign rsp_channel_error = rsp_error_ff;

endmodule

@@ design/iirt_checker.sv @@
// Port-level checks on the IIR filter top level, attached by bind.
// Depends on iirt_pkg and multichannel_iir_transposed_df2_top.
module iirt_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [iirt_pkg::CH_W-1:0]            rsp_channel_out,
   input logic signed [iirt_pkg::SAMPLE_W-1:0] rsp_filtered,
   input logic                                 rsp_channel_error
);
   import iirt_pkg::*;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_filtered)
                                 && $stable(rsp_channel_out)
                                 && $stable(rsp_channel_error))
      else $error("result changed while stalled");

   // A channel error carries a zero sample
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_channel_error |-> rsp_filtered == '0)
      else $error("channel error with nonzero sample");

   // Reset empties the result register and blocks intake
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_ready)
      else $error("result or intake live right after reset");

   // One transaction at a time: no intake in the cycle after an acceptance
   a_one_at_a_time: assert property (@(posedge clock)
      req_valid && req_ready |=> !req_ready)
      else $error("back-to-back acceptance");

endmodule

bind multichannel_iir_transposed_df2_top iirt_checker u_iirt_checker (.*);

@@ verif/tb_top.sv @@
// Self-checking testbench for multichannel_iir_transposed_df2_top: directed and random
// samples through the valid/ready ports, results checked against a bit-exact Q24.24 filter.
// Depends on iirt_pkg and the filter RTL.
module tb_top;
   import iirt_pkg::*;

   localparam int TAPS        = FILTER_ORDER_DEF;
   localparam int CHANS       = MAX_CHANNELS_DEF;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE      = 3 * TAPS + 10;
   localparam int PHASE_ITEMS = 250;

   localparam longint WORD_HI   = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint WORD_LO   = -WORD_HI - 64'sd1;
   localparam longint SAMPLE_HI = 64'sd8388607;
   localparam longint SAMPLE_LO = -64'sd8388608;

   localparam coef_type COEF_MAX = 32'sh7FFF_FFFF;
   localparam coef_type COEF_MIN = 32'sh8000_0000;
   localparam coef_type COEF_ONE = 32'sh1000_0000;
   localparam coef_type COEF_HALF = 32'sh0800_0000;

   // One filtered sample as it leaves the block
   typedef struct packed {
      logic [CH_W-1:0]            chan;
      logic signed [SAMPLE_W-1:0] filtered;
      logic                       err;
   } filter_out_type;

   // Full register image of one filter setting
   typedef struct packed {
      coef_type         b0;
      coef_type         b1;
      coef_type         b2;
      coef_type         b3;
      coef_type         a1;
      coef_type         a2;
      coef_type         a3;
      logic [CHUSE_W-1:0] chuse;
   } filter_setting_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [CH_W-1:0]            req_channel = '0;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [CH_W-1:0]            rsp_channel_out;
   logic signed [SAMPLE_W-1:0] rsp_filtered;
   logic                       rsp_channel_error;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [COEF_W-1:0]          csr_data = '0;

   // Filter state mirrored by the testbench
   coef_type           num_c [NUM_COEF_REGS];
   coef_type           den_c [NUM_COEF_REGS];
   logic [CHUSE_W-1:0] chan_use;
   longint             delay_words [CHANS*TAPS];

   filter_out_type pending_outputs [$];
   int          mismatch_count = 0;
   int          quiet_cycles = 0;
   bit          idle_on = 1'b1;

   always #1 clock = ~clock;

   multichannel_iir_transposed_df2_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_channel       (req_channel),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_channel_out   (rsp_channel_out),
      .rsp_filtered      (rsp_filtered),
      .rsp_channel_error (rsp_channel_error),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   task automatic report_mismatch(input string msg);
      $display("tb_top: mismatch: %s", msg);
      mismatch_count++;
   endtask

   // ---------------- fixed-point filter arithmetic ----------------

   function automatic longint clamp_word(input longint v);
      if (v > WORD_HI) return WORD_HI;
      if (v < WORD_LO) return WORD_LO;
      return v;
   endfunction

   // Q4.28 coefficient times Q24.0 sample, floored to Q24.24
   function automatic longint scale_by_x(input coef_type b, input logic signed [SAMPLE_W-1:0] x);
      longint p;
      p = longint'(b) * longint'(x);
      return p >>> 4;
   endfunction

   // Q4.28 coefficient times Q24.24 word, floored to Q24.24
   function automatic longint scale_by_y(input coef_type a, input longint y);
      logic signed [95:0] p;
      p = a * y;
      p = p >>> 28;
      return $signed(p[63:0]);
   endfunction

   // Expected output for one accepted sample; updates the mirrored delay words
   function automatic filter_out_type predict_filter(input logic [CH_W-1:0] ch,
                                                     input logic signed [SAMPLE_W-1:0] x);
      filter_out_type r;
      longint      y;
      longint      f;
      int          base;
      int          k;
      r.chan     = ch;
      r.err      = 1'b0;
      r.filtered = '0;
      if (int'(ch) >= int'(chan_use) || int'(ch) >= CHANS) begin
         r.err = 1'b1;
         return r;
      end
      base = int'(ch) * TAPS;
      y = clamp_word(scale_by_x(num_c[0], x) + delay_words[base]);
      for (k = 0; k < TAPS - 1; k++) begin
         delay_words[base+k] = clamp_word(scale_by_x(num_c[k+1], x) + delay_words[base+k+1]
                                          - scale_by_y(den_c[k+1], y));
      end
      delay_words[base+TAPS-1] = clamp_word(scale_by_x(num_c[TAPS], x)
                                            - scale_by_y(den_c[TAPS], y));
      // round half up, then clamp to the sample range
      f = (y + 64'sd8388608) >>> 24;
      if (f > SAMPLE_HI) f = SAMPLE_HI;
      if (f < SAMPLE_LO) f = SAMPLE_LO;
      r.filtered = f[SAMPLE_W-1:0];
      return r;
   endfunction

   // ---------------- drivers ----------------

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_NUM_COEF_0:      num_c[0] = data;
         CSR_NUM_COEF_1:      num_c[1] = data;
         CSR_NUM_COEF_2:      num_c[2] = data;
         CSR_NUM_COEF_3:      num_c[3] = data;
         CSR_DEN_COEF_1:      den_c[1] = data;
         CSR_DEN_COEF_2:      den_c[2] = data;
         CSR_DEN_COEF_3:      den_c[3] = data;
         CSR_CHANNELS_IN_USE: chan_use = data[CHUSE_W-1:0];
         default: ;
      endcase
   endtask

   function automatic filter_setting_type make_setting(input coef_type b0, b1, b2, b3,
                                                       a1, a2, a3,
                                                       input logic [CHUSE_W-1:0] chuse);
      filter_setting_type s;
      s.b0 = b0; s.b1 = b1; s.b2 = b2; s.b3 = b3;
      s.a1 = a1; s.a2 = a2; s.a3 = a3;
      s.chuse = chuse;
      return s;
   endfunction

   // Writes every register; only called while no transaction is in flight
   task automatic load_setting(input filter_setting_type s);
      csr_write(CSR_NUM_COEF_0, s.b0);
      csr_write(CSR_NUM_COEF_1, s.b1);
      csr_write(CSR_NUM_COEF_2, s.b2);
      csr_write(CSR_NUM_COEF_3, s.b3);
      csr_write(CSR_DEN_COEF_1, s.a1);
      csr_write(CSR_DEN_COEF_2, s.a2);
      csr_write(CSR_DEN_COEF_3, s.a3);
      csr_write(CSR_CHANNELS_IN_USE, {{(COEF_W-CHUSE_W){1'b0}}, s.chuse});
      csr_valid <= 1'b0;
   endtask

   // Valid stays high between back-to-back samples; it drops only for a gap or a drain
   task automatic send_sample(input logic [CH_W-1:0] ch, input logic signed [SAMPLE_W-1:0] x);
      if (idle_on && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_channel <= ch;
      req_sample  <= x;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_outputs.push_back(predict_filter(ch, x));
   endtask

   task automatic wait_outputs_done();
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
   endtask

   // Mostly served channels, some out of range
   function automatic logic [CH_W-1:0] pick_channel();
      int served;
      served = (int'(chan_use) > CHANS) ? CHANS : int'(chan_use);
      if (served > 0 && $urandom_range(99) < 85) return CH_W'($urandom_range(served - 1));
      return CH_W'($urandom_range(CHANS - 1));
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return 24'sh7FFFFF;
         1:       return 24'sh800000;
         2, 3:    return SAMPLE_W'(int'($urandom_range(2000)) - 1000);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // ---------------- result checker and ready driver ----------------

   always @(posedge clock) begin
      filter_out_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= idle_on ? ($urandom_range(99) >= 7) : 1'b1;
         if (rsp_valid && rsp_ready) begin
            if (pending_outputs.size() == 0) begin
               report_mismatch($sformatf("unexpected result on channel %0d", rsp_channel_out));
            end else begin
               want = pending_outputs.pop_front();
               if (rsp_channel_out !== want.chan)
                  report_mismatch($sformatf("channel_out %0d, want %0d",
                                            rsp_channel_out, want.chan));
               if (rsp_filtered !== want.filtered)
                  report_mismatch($sformatf("ch %0d filtered %0d, want %0d",
                                            want.chan, rsp_filtered, want.filtered));
               if (rsp_channel_error !== want.err)
                  report_mismatch($sformatf("ch %0d channel_error %0b, want %0b",
                                            want.chan, rsp_channel_error, want.err));
            end
         end
      end
   end

   // Watchdog: ends the run when no transaction moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_top: timeout with %0d results outstanding", pending_outputs.size());
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // ---------------- tests ----------------

   // Register defaults: all coefficients zero, one channel served
   task automatic test_reset_state();
      send_sample(3'd0, 24'sh7FFFFF);
      send_sample(3'd3, 24'sh123456);
      wait_outputs_done();
   endtask

   // b0 = 1.0 passes the sample through; sample extremes on several channels
   task automatic test_passthrough();
      load_setting(make_setting(COEF_ONE, 0, 0, 0, 0, 0, 0, 4'd8));
      send_sample(3'd7, 24'sh800000);
      send_sample(3'd0, 24'sh7FFFFF);
      send_sample(3'd3, 24'sh000000);
      send_sample(3'd3, -24'sd1);
      send_sample(3'd5, 24'sd1);
      wait_outputs_done();
   endtask

   // Extreme coefficients drive y, the delay words and the output into saturation
   task automatic test_saturation();
      load_setting(make_setting(COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN,
                                COEF_MAX, COEF_MIN, COEF_MAX, 4'd8));
      send_sample(3'd0, 24'sh7FFFFF);
      send_sample(3'd0, 24'sh800000);
      send_sample(3'd5, 24'sh800000);
      send_sample(3'd5, 24'sh7FFFFF);
      wait_outputs_done();
   endtask

   // Zero channels in use, more than the block holds, and the boundary channel
   task automatic test_channel_limits();
      load_setting(make_setting(COEF_ONE, 0, 0, 0, 0, 0, 0, 4'd0));
      send_sample(3'd0, 24'sd100);
      send_sample(3'd7, 24'sd100);
      wait_outputs_done();
      load_setting(make_setting(COEF_ONE, 0, 0, 0, 0, 0, 0, 4'd15));
      send_sample(3'd7, 24'sd200);
      send_sample(3'd0, -24'sd200);
      wait_outputs_done();
      load_setting(make_setting(COEF_ONE, 0, 0, 0, 0, 0, 0, 4'd5));
      send_sample(3'd4, 24'sd300);
      send_sample(3'd5, 24'sd300);
      wait_outputs_done();
   endtask

   // First-order filter: higher coefficients zero
   task automatic test_low_order();
      load_setting(make_setting(COEF_HALF, COEF_HALF, 0, 0, -COEF_HALF, 0, 0, 4'd3));
      send_sample(3'd2, 24'sh7FFFFF);
      send_sample(3'd2, 24'sh7FFFFF);
      send_sample(3'd2, 24'sh7FFFFF);
      send_sample(3'd2, 24'sh800000);
      wait_outputs_done();
   endtask

   task automatic run_random_phase(input filter_setting_type s, input bit idling);
      int n;
      load_setting(s);
      idle_on = idling;
      for (n = 0; n < PHASE_ITEMS; n++) begin
         send_sample(pick_channel(), pick_sample());
      end
      wait_outputs_done();
   endtask

   // Random samples through stable filters of each order, then random coefficients
   task automatic test_random_filters();
      filter_setting_type lp3;
      lp3 = make_setting(32'sd4858413, 32'sd14575240, 32'sd14575240, 32'sd4858413,
                         -32'sd472446403, 32'sd317530422, -32'sd74640895, 4'd8);
      run_random_phase(lp3, 1'b1);
      lp3.chuse = 4'd4;
      run_random_phase(lp3, 1'b0);
      run_random_phase(make_setting(32'sd141631915, -32'sd424898430, 32'sd424898430,
                                    -32'sd141631915, -32'sd472446403, 32'sd317530422,
                                    -32'sd74640895, 4'd3), 1'b1);
      run_random_phase(make_setting(32'sd18107314, 32'sd36214628, 32'sd18107314, 0,
                                    -32'sd306816358, 32'sd110810692, 0, 4'd8), 1'b1);
      run_random_phase(make_setting(32'sd65830306, 32'sd65830306, 0, 0,
                                    -32'sd136774844, 0, 0, 4'd15), 1'b1);
      run_random_phase(make_setting($urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom, $urandom,
                                    CHUSE_W'($urandom_range(1, 15))), 1'b1);
      run_random_phase(make_setting(int'($urandom_range(536870912)) - 268435456,
                                    int'($urandom_range(536870912)) - 268435456,
                                    int'($urandom_range(536870912)) - 268435456,
                                    int'($urandom_range(536870912)) - 268435456,
                                    int'($urandom_range(536870912)) - 268435456,
                                    int'($urandom_range(536870912)) - 268435456,
                                    int'($urandom_range(536870912)) - 268435456,
                                    4'd8), 1'b1);
   endtask

   // ---------------- sequence ----------------

   initial begin
      int i;
      for (i = 0; i < NUM_COEF_REGS; i++) begin
         num_c[i] = '0;
         den_c[i] = '0;
      end
      for (i = 0; i < CHANS * TAPS; i++) begin
         delay_words[i] = 0;
      end
      chan_use = CHANNELS_IN_USE_RST;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_passthrough();
      test_saturation();
      test_channel_limits();
      test_low_order();
      test_random_filters();
      repeat (SETTLE) @(posedge clock);
      if (pending_outputs.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_outputs.size()));
      if (mismatch_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
